@@ rtl/rccc_pkg.sv @@
package rccc_pkg;

   localparam int FREQ_W  = 20;
   localparam int WB_W    = 16;
   localparam int RATIO_W = 16;
   localparam int CAL_W   = 24;
   localparam int DIV_W   = 32;
   localparam int CLASS_W = 4;
   localparam int ADDR_W  = 3;
   localparam int STABLE_RUN = 3;

   localparam logic [ADDR_W-1:0] REG_BLACK_RED   = 3'd0;
   localparam logic [ADDR_W-1:0] REG_BLACK_GREEN = 3'd1;
   localparam logic [ADDR_W-1:0] REG_BLACK_BLUE  = 3'd2;
   localparam logic [ADDR_W-1:0] REG_BLACK_CLEAR = 3'd3;
   localparam logic [ADDR_W-1:0] REG_WB_RED      = 3'd4;
   localparam logic [ADDR_W-1:0] REG_WB_GREEN    = 3'd5;
   localparam logic [ADDR_W-1:0] REG_WB_BLUE     = 3'd6;

   localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 4'd0;
   localparam logic [CLASS_W-1:0] CLASS_BLACK   = 4'd1;
   localparam logic [CLASS_W-1:0] CLASS_WHITE   = 4'd2;
   localparam logic [CLASS_W-1:0] CLASS_RED     = 4'd3;
   localparam logic [CLASS_W-1:0] CLASS_YELLOW  = 4'd4;
   localparam logic [CLASS_W-1:0] CLASS_GREEN   = 4'd5;
   localparam logic [CLASS_W-1:0] CLASS_CYAN    = 4'd6;
   localparam logic [CLASS_W-1:0] CLASS_BLUE    = 4'd7;
   localparam logic [CLASS_W-1:0] CLASS_MAGENTA = 4'd8;

   // Q16.4 brightness gates: 80 Hz and 650 Hz
   localparam logic [FREQ_W-1:0] DARK_LIMIT   = 20'd1280;
   localparam logic [FREQ_W-1:0] BRIGHT_LIMIT = 20'd10400;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATIO_GO,
      ST_RATIO_WAIT,
      ST_WB_GO,
      ST_WB_WAIT,
      ST_CLASS,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } div_rsp_type;

endpackage

@@ rtl/rccc_div.sv @@
module rccc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rccc_pkg::div_req_type req,
   output rccc_pkg::div_rsp_type rsp
);
   import rccc_pkg::*;

   logic             busy_ff;
   logic             done_ff;
   logic [4:0]       cnt_ff;
   logic [DIV_W-1:0] q_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dv_ff;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             fits;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, q_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dv_ff};
   assign fits  = !diff[DIV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         q_ff   <= req.dividend;
         rem_ff <= '0;
         dv_ff  <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         q_ff   <= {q_ff[DIV_W-2:0], fits};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;

endmodule

@@ rtl/rccc_class.sv @@
module rccc_class (
   input  logic [rccc_pkg::CAL_W-1:0]   cal_red,
   input  logic [rccc_pkg::CAL_W-1:0]   cal_green,
   input  logic [rccc_pkg::CAL_W-1:0]   cal_blue,
   input  logic [rccc_pkg::FREQ_W-1:0]  cal_clear,
   output logic [rccc_pkg::CLASS_W-1:0] cand
);
   import rccc_pkg::*;

   logic signed [31:0] r, g, b, mx, mn, sum, delta, t, u, v;
   logic gray, faint, rg, bg, rb;

   always_comb begin
      r = 32'(signed'({8'd0, cal_red}));
      g = 32'(signed'({8'd0, cal_green}));
      b = 32'(signed'({8'd0, cal_blue}));
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum   = r + g + b;
      delta = mx - mn;
      t = g - b;
      u = b - r;
      v = r - g;
      gray  = (sum == 0) || (delta * 25 < 2 * sum);
      faint = (sum == 0) || (delta * 25 < 3 * sum);
      rg = (g == 0) ? (r > 0) : (2 * r > 5 * g);
      bg = (g == 0) ? (b > 0) : (5 * b > 6 * g);
      rb = (b == 0) ? (r == 0) : (5 * r < 19 * b);

      if (cal_clear < DARK_LIMIT)
         cand = CLASS_BLACK;
      else if (gray && cal_clear > BRIGHT_LIMIT)
         cand = CLASS_WHITE;
      else if (faint)
         cand = CLASS_UNKNOWN;
      else if (rg && bg && rb)
         cand = CLASS_MAGENTA;
      else if (delta == 0)
         cand = CLASS_UNKNOWN;
      else if (mx == r) begin
         if (t >= 0)
            cand = (3 * t <= delta) ? CLASS_RED : CLASS_YELLOW;
         else
            cand = (-4 * t <= delta) ? CLASS_RED : CLASS_MAGENTA;
      end else if (mx == g) begin
         if (-12 * u >= 11 * delta)
            cand = CLASS_YELLOW;
         else if (6 * u <= 5 * delta)
            cand = CLASS_GREEN;
         else
            cand = CLASS_CYAN;
      end else begin
         if (2 * v <= -delta)
            cand = CLASS_CYAN;
         else if (v <= 0)
            cand = CLASS_BLUE;
         else
            cand = CLASS_MAGENTA;
      end
   end

endmodule

@@ rtl/rgb_calibrate_and_classify.sv @@
// Processing: when the dark-corrected clear is zero, the word goes straight to
// classification; else each channel runs the shared 32-step divider twice (ratio, then
// white balance), and a zero white-balance divisor skips its channel.
// Flow: one word in flight; req_tready returns in the cycle after the result leaves.
// Synchronous active-high reset restores register defaults and clears the calibrated values and class history.
module rgb_calibrate_and_classify (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // red_freq, green_freq, blue_freq, clear_freq
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // color_class, candidate_class, clear_valid,
                                   // brightness, zero pad
   input  logic        csr_we,
   input  logic [rccc_pkg::ADDR_W-1:0] csr_addr,
   input  logic [rccc_pkg::FREQ_W-1:0] csr_wdata
);
   import rccc_pkg::*;

   logic [FREQ_W-1:0] blk_ff [4];
   logic [WB_W-1:0]   wb_ff [3];

   state_type state_ff, state_in;
   logic [1:0]         ch_ff, ch_in;
   logic [FREQ_W-1:0]  d_ff [3];
   logic [RATIO_W-1:0] ratio_ff;
   logic [CAL_W-1:0]   cal_ff [3];
   logic [FREQ_W-1:0]  cal_clear_ff;
   logic               valid_ff;
   logic [CLASS_W-1:0] last_ff, shown_ff, cand_ff;
   logic [1:0]         cnt_ff;

   div_req_type dreq;
   div_rsp_type drsp;
   logic [CLASS_W-1:0] cand;
   logic [FREQ_W-1:0]  dk [4];
   logic [WB_W-1:0]    wb_sel;
   logic               accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         dk[i] = (req_tdata[i*FREQ_W +: FREQ_W] > blk_ff[i]) ?
                 req_tdata[i*FREQ_W +: FREQ_W] - blk_ff[i] : '0;
      end
   end

   always_comb begin
      case (ch_ff)
         2'd0:    wb_sel = wb_ff[0];
         2'd1:    wb_sel = wb_ff[1];
         default: wb_sel = wb_ff[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff[0] <= 20'd9970;
         blk_ff[1] <= 20'd9730;
         blk_ff[2] <= 20'd11213;
         blk_ff[3] <= 20'd34000;
         wb_ff[0]  <= 16'd1186;
         wb_ff[1]  <= 16'd1255;
         wb_ff[2]  <= 16'd1539;
      end else if (csr_we) begin
         case (csr_addr)
            REG_BLACK_RED:   blk_ff[0] <= csr_wdata;
            REG_BLACK_GREEN: blk_ff[1] <= csr_wdata;
            REG_BLACK_BLUE:  blk_ff[2] <= csr_wdata;
            REG_BLACK_CLEAR: blk_ff[3] <= csr_wdata;
            REG_WB_RED:      wb_ff[0]  <= csr_wdata[WB_W-1:0];
            REG_WB_GREEN:    wb_ff[1]  <= csr_wdata[WB_W-1:0];
            REG_WB_BLUE:     wb_ff[2]  <= csr_wdata[WB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      dreq.start    = 1'b0;
      dreq.dividend = {d_ff[ch_ff], 12'd0};
      dreq.divisor  = {12'd0, cal_clear_ff};
      case (state_ff)
         ST_IDLE: begin
            ch_in = 2'd0;
            if (accept)
               state_in = (dk[3] != '0) ? ST_RATIO_GO : ST_CLASS;
         end
         ST_RATIO_GO: begin
            // a zero white-balance divisor skips the channel and keeps its held value
            if (wb_sel == '0) begin
               ch_in    = ch_ff + 2'd1;
               state_in = (ch_ff == 2'd2) ? ST_CLASS : ST_RATIO_GO;
            end else begin
               dreq.start = 1'b1;
               state_in   = ST_RATIO_WAIT;
            end
         end
         ST_RATIO_WAIT: if (drsp.done) state_in = ST_WB_GO;
         ST_WB_GO: begin
            dreq.start    = 1'b1;
            dreq.dividend = {ratio_ff, 16'd0};
            dreq.divisor  = {16'd0, wb_sel};
            state_in      = ST_WB_WAIT;
         end
         ST_WB_WAIT: begin
            if (drsp.done) begin
               ch_in    = ch_ff + 2'd1;
               state_in = (ch_ff == 2'd2) ? ST_CLASS : ST_RATIO_GO;
            end
         end
         ST_CLASS: state_in = ST_OUT;
         ST_OUT:   if (rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= 2'd0;
         cal_ff[0]    <= '0;
         cal_ff[1]    <= '0;
         cal_ff[2]    <= '0;
         cal_clear_ff <= '0;
         last_ff      <= CLASS_UNKNOWN;
         shown_ff     <= CLASS_UNKNOWN;
         cnt_ff       <= 2'd0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         if (accept && dk[3] != '0)
            cal_clear_ff <= dk[3];
         if (state_ff == ST_WB_WAIT && drsp.done)
            cal_ff[ch_ff] <= (drsp.quot > 32'hFF_FFFF) ? 24'hFF_FFFF
                                                       : drsp.quot[CAL_W-1:0];
         if (state_ff == ST_CLASS) begin
            if (cand == last_ff) begin
               if (cnt_ff < 2'(STABLE_RUN)) cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff >= 2'(STABLE_RUN - 1)) shown_ff <= cand;
            end else begin
               last_ff <= cand;
               cnt_ff  <= 2'd1;
               if (STABLE_RUN <= 1) shown_ff <= cand;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d_ff[0]  <= dk[0];
         d_ff[1]  <= dk[1];
         d_ff[2]  <= dk[2];
         valid_ff <= (dk[3] != '0);
      end
      if (state_ff == ST_RATIO_WAIT && drsp.done)
         ratio_ff <= (drsp.quot > 32'h0000_FFFF) ? 16'hFFFF : drsp.quot[RATIO_W-1:0];
      if (state_ff == ST_CLASS)
         cand_ff <= cand;
   end

   rccc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   rccc_class u_class (
      .cal_red   (cal_ff[0]),
      .cal_green (cal_ff[1]),
      .cal_blue  (cal_ff[2]),
      .cal_clear (cal_clear_ff),
      .cand      (cand)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {3'd0, cal_clear_ff, valid_ff, cand_ff, shown_ff};

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("result pending while taking words");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready) else $error("second word taken mid item");
   a_done: assert property (@(posedge clock) disable iff (reset)
      drsp.done |-> (state_ff == ST_RATIO_WAIT || state_ff == ST_WB_WAIT))
      else $error("divider finished outside a wait state");
   a_cls: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cand_ff <= CLASS_MAGENTA && shown_ff <= CLASS_MAGENTA))
      else $error("class code out of range");

endmodule
